[hdl/assert_macros.svh]
// Assertion macros used by the RTL datapath of the array unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/iida_pkg.sv]
// Types, constants and codes shared by the indexed insert/delete array unit.
package iida_pkg;

	// Store size and derived widths
	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int FILL_W   = 7;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Request codes
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_READ   = 2'd2
	} req_type_e_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_DONE   = 2'd0,
		STS_BOUNDS = 2'd1,
		STS_FULL   = 2'd2
	} status_e_t;

	// Request beat
	typedef struct packed {
		logic [1:0]               req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} req_t;

	// Result beat
	typedef struct packed {
		logic [1:0]               status;
		logic [FILL_W-1:0]        fill_count;
		logic signed [DATA_W-1:0] read_data;
	} rsp_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT,
		S_FLUSH,
		S_INSVAL,
		S_RESP
	} state_e_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic set_ptr;
		logic shift_rd;
		logic pos_rd;
		logic wr_val;
		logic load_rsp;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic bad;
		logic is_ins;
		logic is_rd;
		logic has_shift;
		logic last;
		logic rsp_free;
	} dp_stat_t;

endpackage

[hdl/indexed_insert_delete_array_unit.sv]
// Indexed insert/delete array unit: top level joining controller and datapath.
// Each request is checked; unless it fails, an insert or delete that moves entries then shifts
// them, one entry per cycle through the single write port of the store, and flushes the last
// write, and an insert writes its value; every request ends with its result beat.
// One request in flight: no new request beat is taken until the result is loaded.
// Reset clears the fill count and the result valid; stored values stay undefined.
module indexed_insert_delete_array_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  iida_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output iida_pkg::rsp_t rsp
);

	iida_pkg::cmd_t     cmd;
	iida_pkg::dp_stat_t stat;

	iida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	iida_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[hdl/iida_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module iida_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/iida_ctrl.sv]
// Controller state machine of the array unit: sequences check, shift, flush, value write and result.
module iida_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  iida_pkg::dp_stat_t stat,
	output iida_pkg::cmd_t    cmd
);

	iida_pkg::state_e_t state_q;
	iida_pkg::state_e_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iida_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			iida_pkg::S_IDLE: begin
				if (req_valid) state_nxt = iida_pkg::S_CHECK;
			end
			iida_pkg::S_CHECK: begin
				if (stat.bad || stat.is_rd) state_nxt = iida_pkg::S_RESP;
				else if (stat.has_shift)    state_nxt = iida_pkg::S_SHIFT;
				else if (stat.is_ins)       state_nxt = iida_pkg::S_INSVAL;
				else                        state_nxt = iida_pkg::S_RESP;
			end
			iida_pkg::S_SHIFT: begin
				if (stat.last) state_nxt = iida_pkg::S_FLUSH;
			end
			iida_pkg::S_FLUSH: begin
				state_nxt = stat.is_ins ? iida_pkg::S_INSVAL : iida_pkg::S_RESP;
			end
			iida_pkg::S_INSVAL: begin
				state_nxt = iida_pkg::S_RESP;
			end
			iida_pkg::S_RESP: begin
				if (stat.rsp_free) state_nxt = iida_pkg::S_IDLE;
			end
			default: state_nxt = iida_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			iida_pkg::S_IDLE: begin
				req_stall    = 1'b0;
				cmd.load_req = req_valid;
			end
			iida_pkg::S_CHECK: begin
				if (!stat.bad) begin
					if (stat.is_rd)          cmd.pos_rd  = 1'b1;
					else if (stat.has_shift) cmd.set_ptr = 1'b1;
				end
			end
			iida_pkg::S_SHIFT: begin
				cmd.shift_rd = 1'b1;
			end
			iida_pkg::S_FLUSH: begin
				// pending shift write completes in the datapath
			end
			iida_pkg::S_INSVAL: begin
				cmd.wr_val = 1'b1;
			end
			iida_pkg::S_RESP: begin
				cmd.load_rsp = stat.rsp_free;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/iida_dpath.sv]
// Datapath of the array unit: request register, fill count, shift pointers, store, result register.
`include "assert_macros.svh"

module iida_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  iida_pkg::req_t     req,
	input  iida_pkg::cmd_t     cmd,
	output iida_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output iida_pkg::rsp_t     rsp
);

	iida_pkg::req_t                   req_q;
	logic [iida_pkg::CNT_W-1:0]       count_q;
	logic [iida_pkg::AW-1:0]          rp_q;
	logic [iida_pkg::AW-1:0]          end_q;
	logic                             pend_s1;
	logic [iida_pkg::AW-1:0]          wadr_s1;
	logic                             rsp_vld_q;
	iida_pkg::rsp_t                   rsp_q;

	logic [iida_pkg::CMP_W-1:0]       pos_c;
	logic [iida_pkg::CMP_W-1:0]       cnt_c;
	logic [iida_pkg::CMP_W:0]         pos_inc_c;
	logic [iida_pkg::AW-1:0]          pos_a;
	logic [iida_pkg::AW-1:0]          cnt_dec_a;
	logic                             is_ins;
	logic                             is_del;
	logic                             is_rd;
	logic                             bad;
	logic                             has_shift;
	iida_pkg::status_e_t              sts;
	logic [iida_pkg::CNT_W-1:0]       count_nxt;

	logic                             mem_we;
	logic [iida_pkg::AW-1:0]          mem_waddr;
	logic [iida_pkg::DATA_W-1:0]      mem_wdata;
	logic                             mem_re;
	logic [iida_pkg::AW-1:0]          mem_raddr;
	logic [iida_pkg::DATA_W-1:0]      mem_rdata;

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	assign pos_c     = iida_pkg::CMP_W'(req_q.position);
	assign cnt_c     = iida_pkg::CMP_W'(count_q);
	assign pos_inc_c = {1'b0, pos_c} + (iida_pkg::CMP_W+1)'(1);
	assign pos_a     = req_q.position[iida_pkg::AW-1:0];
	assign cnt_dec_a = iida_pkg::AW'(count_q - iida_pkg::CNT_W'(1));

	// Request decode and bounds check
	always_comb begin
		is_ins    = 1'b0;
		is_del    = 1'b0;
		is_rd     = 1'b0;
		has_shift = 1'b0;
		sts       = iida_pkg::STS_BOUNDS;
		unique case (req_q.req_type)
			iida_pkg::REQ_INSERT: begin
				is_ins    = 1'b1;
				has_shift = pos_c < cnt_c;
				if (pos_c > cnt_c)
					sts = iida_pkg::STS_BOUNDS;
				else if (cnt_c >= iida_pkg::CMP_W'(iida_pkg::CAPACITY))
					sts = iida_pkg::STS_FULL;
				else
					sts = iida_pkg::STS_DONE;
			end
			iida_pkg::REQ_DELETE: begin
				is_del    = 1'b1;
				has_shift = pos_inc_c < {1'b0, cnt_c};
				sts       = (pos_c < cnt_c) ? iida_pkg::STS_DONE : iida_pkg::STS_BOUNDS;
			end
			iida_pkg::REQ_READ: begin
				is_rd = 1'b1;
				sts   = (pos_c < cnt_c) ? iida_pkg::STS_DONE : iida_pkg::STS_BOUNDS;
			end
			default: sts = iida_pkg::STS_BOUNDS;
		endcase
		bad = (sts != iida_pkg::STS_DONE);
	end

	// Shift pointers: insert walks down from the tail, delete walks up from the hole
	always_ff @(posedge clk) begin
		if (cmd.set_ptr) begin
			if (is_ins) begin
				rp_q  <= cnt_dec_a;
				end_q <= pos_a;
			end else begin
				rp_q  <= pos_a + iida_pkg::AW'(1);
				end_q <= cnt_dec_a;
			end
		end else if (cmd.shift_rd) begin
			rp_q <= is_ins ? rp_q - iida_pkg::AW'(1) : rp_q + iida_pkg::AW'(1);
		end
	end

	// Pending write of the entry read in the previous cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.shift_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_rd) begin
			wadr_s1 <= is_ins ? rp_q + iida_pkg::AW'(1) : rp_q - iida_pkg::AW'(1);
		end
	end

	// Store port selection
	assign mem_we    = pend_s1 | cmd.wr_val;
	assign mem_waddr = cmd.wr_val ? pos_a : wadr_s1;
	assign mem_wdata = cmd.wr_val ? req_q.item_value : mem_rdata;
	assign mem_re    = cmd.shift_rd | cmd.pos_rd;
	assign mem_raddr = cmd.shift_rd ? rp_q : pos_a;

	iida_ram #(
		.WIDTH (iida_pkg::DATA_W),
		.DEPTH (iida_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Fill count after this request
	always_comb begin
		count_nxt = count_q;
		if (!bad && is_ins) count_nxt = count_q + iida_pkg::CNT_W'(1);
		if (!bad && is_del) count_nxt = count_q - iida_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_rsp) begin
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.load_rsp) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q.status     <= sts;
			rsp_q.fill_count <= iida_pkg::FILL_W'(count_nxt);
			rsp_q.read_data  <= (is_rd && !bad) ? mem_rdata : '0;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Status to controller
	assign stat.bad       = bad;
	assign stat.is_ins    = is_ins;
	assign stat.is_rd     = is_rd;
	assign stat.has_shift = has_shift;
	assign stat.last      = (rp_q == end_q);
	assign stat.rsp_free  = !rsp_vld_q || !rsp_stall;

	// Checks
	`ASSERT_ALWAYS(a_count_in_range, count_q <= iida_pkg::CNT_W'(iida_pkg::CAPACITY), "fill count above capacity")
	`ASSERT_ALWAYS(a_one_write, !(pend_s1 && cmd.wr_val), "shift write collides with value write")
	`ASSERT_IMPLY(a_shift_in_fill, cmd.shift_rd, iida_pkg::CNT_W'(rp_q) < count_q, "shift reads beyond fill count")

endmodule
